// File: rtl/lpw_pkg.sv
// Shared types, command codes and a helper function for the LCD window bus sequencer
`timescale 1ns / 1ps

package lpw_pkg;

    // Default largest window side; counts above it saturate
    localparam int DEFAULT_MAX_SIDE = 512;

    // Width of the fill pixel counter (product of two 10-bit counts)
    localparam int FILL_W = 20;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input action codes
    localparam logic [2:0] ACT_WRITE_WIN  = 3'd0;
    localparam logic [2:0] ACT_PIXEL      = 3'd1;
    localparam logic [2:0] ACT_FILL_START = 3'd2;
    localparam logic [2:0] ACT_FILL_TICK  = 3'd3;
    localparam logic [2:0] ACT_ORIENT     = 3'd4;
    localparam logic [2:0] ACT_READ_WIN   = 3'd5;
    localparam logic [2:0] ACT_READ_BYTE  = 3'd6;

    // Panel command bytes
    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
    localparam logic [7:0] CMD_MEM_READ  = 8'h2E;
    localparam logic [7:0] CMD_MEM_ACCESS = 8'h36;

    // Memory access mode bytes per orientation
    localparam logic [7:0] MODE_0   = 8'h48;
    localparam logic [7:0] MODE_90  = 8'h28;
    localparam logic [7:0] MODE_180 = 8'h88;
    localparam logic [7:0] MODE_270 = 8'hE8;

    // Byte positions inside a window sequence
    localparam logic [3:0] WIN_CMD_COL  = 4'd0;
    localparam logic [3:0] WIN_CS_HI    = 4'd1;
    localparam logic [3:0] WIN_CS_LO    = 4'd2;
    localparam logic [3:0] WIN_CE_HI    = 4'd3;
    localparam logic [3:0] WIN_CE_LO    = 4'd4;
    localparam logic [3:0] WIN_CMD_PAGE = 4'd5;
    localparam logic [3:0] WIN_RS_HI    = 4'd6;
    localparam logic [3:0] WIN_RS_LO    = 4'd7;
    localparam logic [3:0] WIN_RE_HI    = 4'd8;
    localparam logic [3:0] WIN_RE_LO    = 4'd9;
    localparam logic [3:0] WIN_CMD_MEM  = 4'd10;

    // Kinds of queued job
    typedef enum logic [1:0] {
        K_WINDOW = 2'd0,
        K_WORD   = 2'd1,
        K_ORIENT = 2'd2,
        K_RPIXEL = 2'd3
    } t_kind;

    // Readback phase, one-hot
    typedef enum logic [4:0] {
        RP_IDLE  = 5'b00001,
        RP_DUMMY = 5'b00010,
        RP_RED   = 5'b00100,
        RP_GREEN = 5'b01000,
        RP_BLUE  = 5'b10000
    } t_rphase;

    // One job handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        rd;      // window ends with memory read command
        logic [8:0]  cs;
        logic [15:0] ce;
        logic [8:0]  rs;
        logic [15:0] re;
        logic [15:0] value;   // pixel word, mode byte or readback pixel
    } t_job;

    // Queue status toward its neighbors
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [7:0] mode_byte(input logic [1:0] orient);
        logic [7:0] m;
        unique case (orient)
            2'd0: m = MODE_0;
            2'd1: m = MODE_90;
            2'd2: m = MODE_180;
            2'd3: m = MODE_270;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/lpw_in_if.sv
// Input channel interface: one action item with its window, color and bus fields.
`timescale 1ns / 1ps

interface lpw_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [8:0]  col_start;
    logic [9:0]  col_count;
    logic [8:0]  row_start;
    logic [9:0]  row_count;
    logic [15:0] pixel_color;
    logic [1:0]  orientation;
    logic [7:0]  bus_in;

    modport source (
        output valid, action, col_start, col_count, row_start, row_count,
               pixel_color, orientation, bus_in,
        input  ready
    );
    modport sink (
        input  valid, action, col_start, col_count, row_start, row_count,
               pixel_color, orientation, bus_in,
        output ready
    );
endinterface

// File: rtl/lpw_out_if.sv
// Output channel interface: one bus byte or readback pixel per item.
`timescale 1ns / 1ps

interface lpw_out_if;
    logic        valid;
    logic        ready;
    logic        is_pixel;
    logic        data_not_cmd;
    logic [7:0]  bus_byte;
    logic [15:0] read_pixel;
    logic        last;

    modport source (
        output valid, is_pixel, data_not_cmd, bus_byte, read_pixel, last,
        input  ready
    );
    modport sink (
        input  valid, is_pixel, data_not_cmd, bus_byte, read_pixel, last,
        output ready
    );
endinterface

// File: rtl/lpw_front.sv
// Front end: accepts actions, tracks fill and readback state, builds jobs.
`timescale 1ns / 1ps

module lpw_front #(
    parameter int MAX_SIDE = lpw_pkg::DEFAULT_MAX_SIDE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpw_in_if.sink        i_in,
    input  lpw_pkg::t_qstat i_qstat,
    output logic          o_push,
    output lpw_pkg::t_job o_job
);

    logic                      accept;
    logic [9:0]                cc_sat;
    logic [9:0]                rc_sat;
    logic [lpw_pkg::FILL_W-1:0] fill_total;
    lpw_pkg::t_job             win_job;
    logic                      produce;

    logic [lpw_pkg::FILL_W-1:0] r_fill_left, n_fill_left;
    logic [15:0]               r_fill_color, n_fill_color;
    lpw_pkg::t_rphase          r_phase, n_phase;
    logic [7:0]                r_red, n_red;
    logic [7:0]                r_green, n_green;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && produce;

    // Saturate counts to the largest side
    assign cc_sat = ({22'd0, i_in.col_count} > 32'(MAX_SIDE)) ? 10'(MAX_SIDE)
                                                              : i_in.col_count;
    assign rc_sat = ({22'd0, i_in.row_count} > 32'(MAX_SIDE)) ? 10'(MAX_SIDE)
                                                              : i_in.row_count;
    assign fill_total = lpw_pkg::FILL_W'(cc_sat) * lpw_pkg::FILL_W'(rc_sat);

    // Window addresses; end wraps at 16 bits for a zero count
    always_comb begin
        win_job       = '0;
        win_job.kind  = lpw_pkg::K_WINDOW;
        win_job.cs    = i_in.col_start;
        win_job.ce    = 16'(i_in.col_start) + 16'(cc_sat) - 16'd1;
        win_job.rs    = i_in.row_start;
        win_job.re    = 16'(i_in.row_start) + 16'(rc_sat) - 16'd1;
    end

    // Classify the action and update state
    always_comb begin
        produce      = 1'b0;
        o_job        = win_job;
        n_fill_left  = r_fill_left;
        n_fill_color = r_fill_color;
        n_phase      = r_phase;
        n_red        = r_red;
        n_green      = r_green;
        unique case (i_in.action)
            lpw_pkg::ACT_WRITE_WIN: begin
                produce = 1'b1;
                n_phase = lpw_pkg::RP_IDLE;
            end
            lpw_pkg::ACT_PIXEL: begin
                produce     = 1'b1;
                o_job.kind  = lpw_pkg::K_WORD;
                o_job.value = i_in.pixel_color;
            end
            lpw_pkg::ACT_FILL_START: begin
                produce      = 1'b1;
                n_fill_left  = fill_total;
                n_fill_color = i_in.pixel_color;
                n_phase      = lpw_pkg::RP_IDLE;
            end
            lpw_pkg::ACT_FILL_TICK: begin
                if (r_fill_left != '0) begin
                    produce     = 1'b1;
                    o_job.kind  = lpw_pkg::K_WORD;
                    o_job.value = r_fill_color;
                    n_fill_left = r_fill_left - 1'b1;
                end
            end
            lpw_pkg::ACT_ORIENT: begin
                produce     = 1'b1;
                o_job.kind  = lpw_pkg::K_ORIENT;
                o_job.value = {8'd0, lpw_pkg::mode_byte(i_in.orientation)};
                n_phase     = lpw_pkg::RP_IDLE;
            end
            lpw_pkg::ACT_READ_WIN: begin
                produce  = 1'b1;
                o_job.rd = 1'b1;
                n_phase  = lpw_pkg::RP_DUMMY;
            end
            lpw_pkg::ACT_READ_BYTE: begin
                unique case (r_phase)
                    lpw_pkg::RP_DUMMY: n_phase = lpw_pkg::RP_RED;
                    lpw_pkg::RP_RED: begin
                        n_red   = i_in.bus_in;
                        n_phase = lpw_pkg::RP_GREEN;
                    end
                    lpw_pkg::RP_GREEN: begin
                        n_green = i_in.bus_in;
                        n_phase = lpw_pkg::RP_BLUE;
                    end
                    lpw_pkg::RP_BLUE: begin
                        produce     = 1'b1;
                        o_job.kind  = lpw_pkg::K_RPIXEL;
                        o_job.value = {r_red[7:3], r_green[7:2], i_in.bus_in[7:3]};
                        n_phase     = lpw_pkg::RP_RED;
                    end
                    default: n_phase = r_phase;
                endcase
            end
            default: produce = 1'b0;
        endcase
    end

    // State registers, updated only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_left  <= '0;
            r_fill_color <= '0;
            r_phase      <= lpw_pkg::RP_IDLE;
            r_red        <= '0;
            r_green      <= '0;
        end else if (accept) begin
            r_fill_left  <= n_fill_left;
            r_fill_color <= n_fill_color;
            r_phase      <= n_phase;
            r_red        <= n_red;
            r_green      <= n_green;
        end
    end

endmodule

// File: rtl/lpw_queue.sv
// Short job queue that decouples the front end from the byte sequencer.
`timescale 1ns / 1ps

module lpw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpw_pkg::t_job   i_job,
    input  logic            i_pop,
    output lpw_pkg::t_job   o_job,
    output lpw_pkg::t_qstat o_qstat
);

    lpw_pkg::t_job                   r_slot [lpw_pkg::QUEUE_DEPTH];
    logic [lpw_pkg::QPTR_W-1:0]      r_wr, r_rd;
    logic [lpw_pkg::QPTR_W:0]        r_count;

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == (lpw_pkg::QPTR_W+1)'(lpw_pkg::QUEUE_DEPTH));
    assign o_job         = r_slot[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/lpw_back.sv
// Back end: expands jobs into bytes and read pixels, one per cycle unless stalled.
`timescale 1ns / 1ps

module lpw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpw_pkg::t_job   i_job,
    input  lpw_pkg::t_qstat i_qstat,
    output logic            o_pop,
    lpw_out_if.source       o_out
);

    logic        load;
    logic [3:0]  last_step;
    logic        step_last;
    logic        c_pix;
    logic        c_dnc;
    logic [7:0]  c_byte;
    logic [15:0] c_rpix;

    logic [3:0]  r_step;
    logic        r_valid;
    logic        r_pix;
    logic        r_dnc;
    logic [7:0]  r_byte;
    logic [15:0] r_rpix;
    logic        r_last;

    assign load      = !r_valid || o_out.ready;
    assign step_last = (r_step == last_step);
    assign o_pop     = load && !i_qstat.empty && step_last;

    // Byte selection for the current step of the head job
    always_comb begin
        c_pix     = 1'b0;
        c_dnc     = 1'b1;
        c_byte    = '0;
        c_rpix    = '0;
        last_step = '0;
        unique case (i_job.kind)
            lpw_pkg::K_WINDOW: begin
                last_step = lpw_pkg::WIN_CMD_MEM;
                case (r_step)
                    lpw_pkg::WIN_CMD_COL: begin
                        c_dnc  = 1'b0;
                        c_byte = lpw_pkg::CMD_COL_ADDR;
                    end
                    lpw_pkg::WIN_CS_HI:   c_byte = {7'd0, i_job.cs[8]};
                    lpw_pkg::WIN_CS_LO:   c_byte = i_job.cs[7:0];
                    lpw_pkg::WIN_CE_HI:   c_byte = i_job.ce[15:8];
                    lpw_pkg::WIN_CE_LO:   c_byte = i_job.ce[7:0];
                    lpw_pkg::WIN_CMD_PAGE: begin
                        c_dnc  = 1'b0;
                        c_byte = lpw_pkg::CMD_PAGE_ADDR;
                    end
                    lpw_pkg::WIN_RS_HI:   c_byte = {7'd0, i_job.rs[8]};
                    lpw_pkg::WIN_RS_LO:   c_byte = i_job.rs[7:0];
                    lpw_pkg::WIN_RE_HI:   c_byte = i_job.re[15:8];
                    lpw_pkg::WIN_RE_LO:   c_byte = i_job.re[7:0];
                    lpw_pkg::WIN_CMD_MEM: begin
                        c_dnc  = 1'b0;
                        c_byte = i_job.rd ? lpw_pkg::CMD_MEM_READ : lpw_pkg::CMD_MEM_WRITE;
                    end
                    default: c_byte = '0;
                endcase
            end
            lpw_pkg::K_WORD: begin
                last_step = 4'd1;
                c_byte    = r_step[0] ? i_job.value[7:0] : i_job.value[15:8];
            end
            lpw_pkg::K_ORIENT: begin
                last_step = 4'd1;
                c_dnc     = r_step[0];
                c_byte    = r_step[0] ? i_job.value[7:0] : lpw_pkg::CMD_MEM_ACCESS;
            end
            lpw_pkg::K_RPIXEL: begin
                last_step = 4'd0;
                c_pix     = 1'b1;
                c_dnc     = 1'b0;
                c_rpix    = i_job.value;
            end
        endcase
    end

    // Step counter and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_step <= step_last ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load && !i_qstat.empty) begin
            r_pix  <= c_pix;
            r_dnc  <= c_dnc;
            r_byte <= c_byte;
            r_rpix <= c_rpix;
            r_last <= step_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.is_pixel     = r_pix;
    assign o_out.data_not_cmd = r_dnc;
    assign o_out.bus_byte     = r_byte;
    assign o_out.read_pixel   = r_rpix;
    assign o_out.last         = r_last;

endmodule

// File: rtl/lcd_parallel_window_bus_sequencer.sv
// Top level of the 8080-style LCD window bus sequencer.
`timescale 1ns / 1ps

// The front end accepts one action per cycle while its four-entry job queue
// has room; it keeps the fill counter and readback phase itself, so actions
// wait only for queue room, not on the bus. The back end drives one result
// per cycle, while the output is ready, through a registered output stage:
// a write window, read window or fill start gives 11 bytes, a pixel, fill
// tick or orientation gives 2 bytes, and a completed readback pixel gives
// one item; dropped read bytes, empty fill ticks and unused codes give none.
// The output register sets the sustained rate, so a stream of pixels or fill
// ticks is limited by the two bytes that each item gives.
// Counts above MAX_SIDE saturate to MAX_SIDE.

module lcd_parallel_window_bus_sequencer #(
    parameter int MAX_SIDE = lpw_pkg::DEFAULT_MAX_SIDE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpw_in_if.sink    i_in,
    lpw_out_if.source o_out
);

    logic            push;
    logic            pop;
    lpw_pkg::t_job   front_job;
    lpw_pkg::t_job   head_job;
    lpw_pkg::t_qstat qstat;

    lpw_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (front_job)
    );

    lpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    lpw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
